// File: hdl/lavm_pkg.sv
// Package for the look-at view matrix core: field widths, fixed-point constants,
// register indexes and the vector types shared by the datapath modules.
// No dependencies.
package lavm_pkg;

    localparam int UNIT_W      = 18;
    localparam int POS_W       = 32;
    localparam int VEC_W       = 36;
    localparam int MAG_W       = 36;
    localparam int LEAD_W      = 6;
    localparam int LEAD_TARGET = 30;
    localparam int NRM_W       = 31;
    localparam int SQ_W        = 62;
    localparam int SUM_W       = 64;
    localparam int ROOT_STEPS  = 32;
    localparam int ROOT_W      = 32;
    localparam int FRAC_W      = 16;
    localparam int DVD_W       = 48;
    localparam int DIV_STEPS   = 18;
    localparam int DVS_W       = 50;
    localparam int PROD_W      = 50;
    localparam int DOT_W       = 52;

    localparam int ADDR_W      = 4;
    localparam int APB_W       = 32;
    localparam int IN_W        = 192;
    localparam int OUT_W       = 264;

    localparam logic [DIV_STEPS-1:0] ONE_Q16 = DIV_STEPS'(65536);

    localparam logic [1:0] REG_UP_X = 2'd0;
    localparam logic [1:0] REG_UP_Y = 2'd1;
    localparam logic [1:0] REG_UP_Z = 2'd2;

    typedef struct packed {
        logic signed [UNIT_W-1:0] z;
        logic signed [UNIT_W-1:0] y;
        logic signed [UNIT_W-1:0] x;
    } unit_t;

    typedef struct packed {
        logic signed [VEC_W-1:0] z;
        logic signed [VEC_W-1:0] y;
        logic signed [VEC_W-1:0] x;
    } vin_t;

    typedef struct packed {
        logic signed [POS_W-1:0] z;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] x;
    } pos_t;

endpackage

// File: hdl/lavm_norm.sv
// Pipelined vector normalizer: magnitude scaling, sum of squares, digit-by-digit
// square root and a restoring divider per lane, one stage each step.
// Depends on lavm_pkg.
module lavm_norm #(
    parameter int SIDE_W = 96
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  lavm_pkg::vin_t      in_vec,
    input  logic [SIDE_W-1:0]   in_side,
    output logic                out_valid,
    output lavm_pkg::unit_t     out_vec,
    output logic [SIDE_W-1:0]   out_side
);

    localparam int MAG_W  = lavm_pkg::MAG_W;
    localparam int NRM_W  = lavm_pkg::NRM_W;
    localparam int SQ_W   = lavm_pkg::SQ_W;
    localparam int SUM_W  = lavm_pkg::SUM_W;
    localparam int RSTEPS = lavm_pkg::ROOT_STEPS;
    localparam int DSTEPS = lavm_pkg::DIV_STEPS;
    localparam int DVD_W  = lavm_pkg::DVD_W;
    localparam int DVS_W  = lavm_pkg::DVS_W;
    localparam int ROOT_W = lavm_pkg::ROOT_W;
    localparam int LEAD_W = lavm_pkg::LEAD_W;
    localparam int UNIT_W = lavm_pkg::UNIT_W;

    logic signed [lavm_pkg::VEC_W-1:0] vin [3];

    // Stage A: magnitudes and maximum.
    logic                a_valid_reg;
    logic [MAG_W-1:0]    a_mag_reg [3];
    logic [MAG_W-1:0]    a_mag_next [3];
    logic [2:0]          a_neg_reg;
    logic [MAG_W-1:0]    a_max_reg;
    logic [MAG_W-1:0]    a_max_next;
    logic [SIDE_W-1:0]   a_side_reg;

    // Stage B: leading one position.
    logic                b_valid_reg;
    logic [MAG_W-1:0]    b_mag_reg [3];
    logic [2:0]          b_neg_reg;
    logic [LEAD_W-1:0]   b_lead_reg;
    logic [LEAD_W-1:0]   b_lead_next;
    logic                b_zero_reg;
    logic [SIDE_W-1:0]   b_side_reg;

    // Stage C: scaled magnitudes.
    logic                c_valid_reg;
    logic [NRM_W-1:0]    c_m_reg [3];
    logic [NRM_W-1:0]    c_m_next [3];
    logic [2:0]          c_neg_reg;
    logic                c_zero_reg;
    logic [SIDE_W-1:0]   c_side_reg;

    // Stage D: squares.
    logic                d_valid_reg;
    logic [SQ_W-1:0]     d_sq_reg [3];
    logic [NRM_W-1:0]    d_m_reg [3];
    logic [2:0]          d_neg_reg;
    logic                d_zero_reg;
    logic [SIDE_W-1:0]   d_side_reg;

    // Square root chain; index 0 holds the sum of squares.
    logic                sq_valid_reg [RSTEPS+1];
    logic [SUM_W-1:0]    sq_rem_reg   [RSTEPS+1];
    logic [SUM_W-1:0]    sq_root_reg  [RSTEPS+1];
    logic [NRM_W-1:0]    sq_m_reg     [RSTEPS+1][3];
    logic [2:0]          sq_neg_reg   [RSTEPS+1];
    logic                sq_zero_reg  [RSTEPS+1];
    logic [SIDE_W-1:0]   sq_side_reg  [RSTEPS+1];

    // Divider chain; index 0 holds the rounded dividends.
    logic                dv_valid_reg [DSTEPS+1];
    logic [DVD_W-1:0]    dv_rem_reg   [DSTEPS+1][3];
    logic [DSTEPS-1:0]   dv_q_reg     [DSTEPS+1][3];
    logic [ROOT_W-1:0]   dv_n_reg     [DSTEPS+1];
    logic [2:0]          dv_neg_reg   [DSTEPS+1];
    logic                dv_zero_reg  [DSTEPS+1];
    logic [SIDE_W-1:0]   dv_side_reg  [DSTEPS+1];

    logic                o_valid_reg;
    lavm_pkg::unit_t     o_vec_reg;
    lavm_pkg::unit_t     o_vec_next;
    logic [SIDE_W-1:0]   o_side_reg;

    logic [ROOT_W-1:0]   root_n;
    logic [DSTEPS-1:0]   clamp_q [3];
    logic [UNIT_W-1:0]   unit_val [3];

    assign vin[0] = in_vec.x;
    assign vin[1] = in_vec.y;
    assign vin[2] = in_vec.z;

    always_comb
    begin
        a_max_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            a_mag_next[i] = vin[i][lavm_pkg::VEC_W-1] ? MAG_W'(-vin[i]) : MAG_W'(vin[i]);
        end
        for (int i = 0; i < 3; i++)
        begin
            if (a_mag_next[i] > a_max_next)
            begin
                a_max_next = a_mag_next[i];
            end
        end
    end

    always_comb
    begin
        b_lead_next = '0;
        for (int k = 0; k < MAG_W; k++)
        begin
            if (a_max_reg[k])
            begin
                b_lead_next = LEAD_W'(k);
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (b_lead_reg > LEAD_W'(lavm_pkg::LEAD_TARGET))
            begin
                c_m_next[i] = NRM_W'(b_mag_reg[i] >>
                    (b_lead_reg - LEAD_W'(lavm_pkg::LEAD_TARGET)));
            end
            else
            begin
                c_m_next[i] = NRM_W'(b_mag_reg[i] <<
                    (LEAD_W'(lavm_pkg::LEAD_TARGET) - b_lead_reg));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg     <= 1'b0;
            b_valid_reg     <= 1'b0;
            c_valid_reg     <= 1'b0;
            d_valid_reg     <= 1'b0;
            sq_valid_reg[0] <= 1'b0;
            dv_valid_reg[0] <= 1'b0;
            o_valid_reg     <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg     <= in_valid;
            b_valid_reg     <= a_valid_reg;
            c_valid_reg     <= b_valid_reg;
            d_valid_reg     <= c_valid_reg;
            sq_valid_reg[0] <= d_valid_reg;
            dv_valid_reg[0] <= sq_valid_reg[RSTEPS];
            o_valid_reg     <= dv_valid_reg[DSTEPS];
        end
    end

    assign root_n = sq_root_reg[RSTEPS][ROOT_W-1:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                a_mag_reg[i] <= a_mag_next[i];
                a_neg_reg[i] <= vin[i][lavm_pkg::VEC_W-1];
                b_mag_reg[i] <= a_mag_reg[i];
                c_m_reg[i]   <= c_m_next[i];
                d_sq_reg[i]  <= SQ_W'(c_m_reg[i]) * SQ_W'(c_m_reg[i]);
                d_m_reg[i]   <= c_m_reg[i];
                sq_m_reg[0][i] <= d_m_reg[i];
                dv_rem_reg[0][i] <= DVD_W'({sq_m_reg[RSTEPS][i], {lavm_pkg::FRAC_W{1'b0}}})
                                    + DVD_W'(root_n[ROOT_W-1:1]);
                dv_q_reg[0][i] <= '0;
            end
            a_max_reg  <= a_max_next;
            a_side_reg <= in_side;
            b_neg_reg  <= a_neg_reg;
            b_lead_reg <= b_lead_next;
            b_zero_reg <= (a_max_reg == '0);
            b_side_reg <= a_side_reg;
            c_neg_reg  <= b_neg_reg;
            c_zero_reg <= b_zero_reg;
            c_side_reg <= b_side_reg;
            d_neg_reg  <= c_neg_reg;
            d_zero_reg <= c_zero_reg;
            d_side_reg <= c_side_reg;
            sq_rem_reg[0]  <= SUM_W'(d_sq_reg[0]) + SUM_W'(d_sq_reg[1]) + SUM_W'(d_sq_reg[2]);
            sq_root_reg[0] <= '0;
            sq_neg_reg[0]  <= d_neg_reg;
            sq_zero_reg[0] <= d_zero_reg;
            sq_side_reg[0] <= d_side_reg;
            dv_n_reg[0]    <= root_n;
            dv_neg_reg[0]  <= sq_neg_reg[RSTEPS];
            dv_zero_reg[0] <= sq_zero_reg[RSTEPS];
            dv_side_reg[0] <= sq_side_reg[RSTEPS];
            o_vec_reg      <= o_vec_next;
            o_side_reg     <= dv_side_reg[DSTEPS];
        end
    end

    for (genvar k = 1; k <= RSTEPS; k++)
    begin : g_sqrt
        localparam int BitPos = 2 * (RSTEPS - k);
        localparam logic [SUM_W:0] BitVal = (SUM_W+1)'(1) << BitPos;
        logic [SUM_W:0]   trial;
        logic [SUM_W-1:0] rem_next;
        logic [SUM_W-1:0] root_next;

        always_comb
        begin
            trial = {1'b0, sq_root_reg[k-1]} + BitVal;
            if ({1'b0, sq_rem_reg[k-1]} >= trial)
            begin
                rem_next  = sq_rem_reg[k-1] - trial[SUM_W-1:0];
                root_next = (sq_root_reg[k-1] >> 1) + BitVal[SUM_W-1:0];
            end
            else
            begin
                rem_next  = sq_rem_reg[k-1];
                root_next = sq_root_reg[k-1] >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                sq_valid_reg[k] <= sq_valid_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_rem_reg[k]  <= rem_next;
                sq_root_reg[k] <= root_next;
                sq_m_reg[k]    <= sq_m_reg[k-1];
                sq_neg_reg[k]  <= sq_neg_reg[k-1];
                sq_zero_reg[k] <= sq_zero_reg[k-1];
                sq_side_reg[k] <= sq_side_reg[k-1];
            end
        end
    end

    for (genvar j = 1; j <= DSTEPS; j++)
    begin : g_div
        localparam int Shift = DSTEPS - j;
        logic [DVS_W-1:0] dvs;
        logic [DVD_W-1:0] rem_next [3];
        logic [DSTEPS-1:0] q_next [3];

        always_comb
        begin
            dvs = DVS_W'(dv_n_reg[j-1]) << Shift;
            for (int i = 0; i < 3; i++)
            begin
                if (DVS_W'(dv_rem_reg[j-1][i]) >= dvs)
                begin
                    rem_next[i] = dv_rem_reg[j-1][i] - dvs[DVD_W-1:0];
                    q_next[i]   = {dv_q_reg[j-1][i][DSTEPS-2:0], 1'b1};
                end
                else
                begin
                    rem_next[i] = dv_rem_reg[j-1][i];
                    q_next[i]   = {dv_q_reg[j-1][i][DSTEPS-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_valid_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                dv_valid_reg[j] <= dv_valid_reg[j-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_rem_reg[j]  <= rem_next;
                dv_q_reg[j]    <= q_next;
                dv_n_reg[j]    <= dv_n_reg[j-1];
                dv_neg_reg[j]  <= dv_neg_reg[j-1];
                dv_zero_reg[j] <= dv_zero_reg[j-1];
                dv_side_reg[j] <= dv_side_reg[j-1];
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            clamp_q[i] = (dv_q_reg[DSTEPS][i] > lavm_pkg::ONE_Q16) ?
                         lavm_pkg::ONE_Q16 : dv_q_reg[DSTEPS][i];
            if (dv_zero_reg[DSTEPS])
            begin
                unit_val[i] = '0;
            end
            else if (dv_neg_reg[DSTEPS][i])
            begin
                unit_val[i] = UNIT_W'(-clamp_q[i]);
            end
            else
            begin
                unit_val[i] = UNIT_W'(clamp_q[i]);
            end
        end
        o_vec_next.x = unit_val[0];
        o_vec_next.y = unit_val[1];
        o_vec_next.z = unit_val[2];
    end

    assign out_valid = o_valid_reg;
    assign out_vec   = o_vec_reg;
    assign out_side  = o_side_reg;

endmodule

// File: hdl/lavm_cross.sv
// Two-stage cross product of two unit vectors in Q1.16, giving a Q2.32 vector.
// Depends on lavm_pkg.
module lavm_cross #(
    parameter int SIDE_W = 150
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  lavm_pkg::unit_t     a,
    input  lavm_pkg::unit_t     b,
    input  logic [SIDE_W-1:0]   in_side,
    output logic                out_valid,
    output lavm_pkg::vin_t      out_vec,
    output logic [SIDE_W-1:0]   out_side
);

    localparam int VEC_W = lavm_pkg::VEC_W;

    logic                    p_valid_reg;
    logic signed [VEC_W-1:0] p_reg [6];
    logic [SIDE_W-1:0]       p_side_reg;
    logic                    o_valid_reg;
    lavm_pkg::vin_t          o_vec_reg;
    logic [SIDE_W-1:0]       o_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            p_valid_reg <= in_valid;
            o_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg[0]    <= VEC_W'(a.y) * VEC_W'(b.z);
            p_reg[1]    <= VEC_W'(a.z) * VEC_W'(b.y);
            p_reg[2]    <= VEC_W'(a.z) * VEC_W'(b.x);
            p_reg[3]    <= VEC_W'(a.x) * VEC_W'(b.z);
            p_reg[4]    <= VEC_W'(a.x) * VEC_W'(b.y);
            p_reg[5]    <= VEC_W'(a.y) * VEC_W'(b.x);
            p_side_reg  <= in_side;
            o_vec_reg.x <= p_reg[0] - p_reg[1];
            o_vec_reg.y <= p_reg[2] - p_reg[3];
            o_vec_reg.z <= p_reg[4] - p_reg[5];
            o_side_reg  <= p_side_reg;
        end
    end

    assign out_valid = o_valid_reg;
    assign out_vec   = o_vec_reg;
    assign out_side  = o_side_reg;

endmodule

// File: hdl/lavm_xlate.sv
// Translation column: negated dot products of the three rotation rows with the
// position, rounded to Q16.16 and saturated, in three stages. Depends on lavm_pkg.
module lavm_xlate (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            in_valid,
    input  lavm_pkg::unit_t                 rows_in [3],
    input  lavm_pkg::pos_t                  pos,
    output logic                            out_valid,
    output lavm_pkg::unit_t                 rows_out [3],
    output logic signed [lavm_pkg::POS_W-1:0] trans [3]
);

    localparam int PROD_W = lavm_pkg::PROD_W;
    localparam int DOT_W  = lavm_pkg::DOT_W;
    localparam int POS_W  = lavm_pkg::POS_W;
    localparam int FRAC_W = lavm_pkg::FRAC_W;
    localparam logic signed [DOT_W-1:0] HALF_LSB = DOT_W'(1) << (FRAC_W - 1);
    localparam logic signed [DOT_W-1:0] SAT_MAX  = (DOT_W'(1) << (POS_W - 1)) - DOT_W'(1);
    localparam logic signed [DOT_W-1:0] SAT_MIN  = -(DOT_W'(1) << (POS_W - 1));

    logic                     m_valid_reg;
    logic signed [PROD_W-1:0] m_prod_reg [3][3];
    lavm_pkg::unit_t          m_rows_reg [3];
    logic                     s_valid_reg;
    logic signed [DOT_W-1:0]  s_dot_reg [3];
    lavm_pkg::unit_t          s_rows_reg [3];
    logic                     o_valid_reg;
    logic signed [POS_W-1:0]  o_trans_reg [3];
    logic signed [POS_W-1:0]  o_trans_next [3];
    lavm_pkg::unit_t          o_rows_reg [3];
    logic signed [DOT_W-1:0]  rnd [3];

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            rnd[r] = (HALF_LSB - s_dot_reg[r]) >>> FRAC_W;
            if (rnd[r] > SAT_MAX)
            begin
                o_trans_next[r] = SAT_MAX[POS_W-1:0];
            end
            else if (rnd[r] < SAT_MIN)
            begin
                o_trans_next[r] = SAT_MIN[POS_W-1:0];
            end
            else
            begin
                o_trans_next[r] = rnd[r][POS_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            s_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            m_valid_reg <= in_valid;
            s_valid_reg <= m_valid_reg;
            o_valid_reg <= s_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
            begin
                m_prod_reg[r][0] <= PROD_W'(rows_in[r].x) * PROD_W'(pos.x);
                m_prod_reg[r][1] <= PROD_W'(rows_in[r].y) * PROD_W'(pos.y);
                m_prod_reg[r][2] <= PROD_W'(rows_in[r].z) * PROD_W'(pos.z);
                s_dot_reg[r]     <= DOT_W'(m_prod_reg[r][0]) + DOT_W'(m_prod_reg[r][1])
                                    + DOT_W'(m_prod_reg[r][2]);
                o_trans_reg[r]   <= o_trans_next[r];
            end
            m_rows_reg <= rows_in;
            s_rows_reg <= m_rows_reg;
            o_rows_reg <= s_rows_reg;
        end
    end

    assign out_valid = o_valid_reg;
    assign rows_out  = o_rows_reg;
    assign trans     = o_trans_reg;

endmodule

// File: hdl/lavm_obuf.sv
// Two-entry output buffer that decouples the pipeline from the result receiver.
// Depends on nothing.
module lavm_obuf #(
    parameter int W = 264
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic [W-1:0] in_data,
    output logic         in_ready,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [W-1:0] out_data
);

    logic [W-1:0] mem_reg [2];
    logic         wr_ptr_reg;
    logic         rd_ptr_reg;
    logic [1:0]   count_reg;
    logic [1:0]   count_next;
    logic         push;
    logic         pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid & in_ready;
    assign pop       = out_valid & out_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

// File: hdl/look_at_view_matrix_core.sv
// Top level of the look-at view matrix core: APB register file, three normalizers,
// two cross products, the translation column and the output buffer.
// Depends on lavm_pkg, lavm_norm, lavm_cross, lavm_xlate and lavm_obuf.
//
// The slave stream carries one camera transaction: position and front vector,
// six signed Q16.16 words. The master stream returns the twelve non-constant view
// matrix entries: three unit rows in Q1.16 and the saturated Q16.16 translation.
// The world up vector sits in three APB registers at byte addresses 0, 4 and 8;
// write them only while no transaction is in flight.
// One transaction is accepted per cycle while s_tready is high. A result appears on the
// master side after passing the three 57-stage normalizers (square root and divider
// steps), the cross product and translation stages and the output buffer.
// Reset empties the pipeline and loads the up vector with 0, 1.0, 0.
// When the receiver stalls, a two-entry buffer holds finished results; once it is
// full the whole pipeline freezes and s_tready drops until a result is taken.
module look_at_view_matrix_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // pos_x, pos_y, pos_z, front_x, front_y, front_z (32 bits each)
    input  logic [lavm_pkg::IN_W-1:0]      s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // right_x/y/z, upv_x/y/z, back_x/y/z (18 bits each),
    // trans_0, trans_1, trans_2 (32 bits each), zero padding
    output logic [lavm_pkg::OUT_W-1:0]     m_tdata,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lavm_pkg::ADDR_W-1:0]    paddr,
    input  logic [lavm_pkg::APB_W-1:0]     pwdata,
    output logic [lavm_pkg::APB_W-1:0]     prdata,
    output logic                           pready
);

    localparam int UNIT_W = lavm_pkg::UNIT_W;
    localparam int POS_W  = lavm_pkg::POS_W;
    localparam int VEC_W  = lavm_pkg::VEC_W;
    localparam int SIDE1  = $bits(lavm_pkg::pos_t);
    localparam int SIDE2  = SIDE1 + $bits(lavm_pkg::unit_t);
    localparam int SIDE3  = SIDE2 + $bits(lavm_pkg::unit_t);

    logic signed [UNIT_W-1:0] up_x_reg;
    logic signed [UNIT_W-1:0] up_y_reg;
    logic signed [UNIT_W-1:0] up_z_reg;
    logic                     cfg_wr;
    logic [1:0]               cfg_idx;

    logic                     en;
    lavm_pkg::pos_t           in_pos;
    lavm_pkg::vin_t           neg_front;
    lavm_pkg::unit_t          up_vec;

    logic                     n1_valid;
    lavm_pkg::unit_t          n1_back;
    logic [SIDE1-1:0]         n1_side;
    logic                     c1_valid;
    lavm_pkg::vin_t           c1_vec;
    logic [SIDE2-1:0]         c1_side;
    logic                     n2_valid;
    lavm_pkg::unit_t          n2_right;
    logic [SIDE2-1:0]         n2_side;
    lavm_pkg::unit_t          n2_back;
    logic                     c2_valid;
    lavm_pkg::vin_t           c2_vec;
    logic [SIDE3-1:0]         c2_side;
    logic                     n3_valid;
    lavm_pkg::unit_t          n3_cup;
    logic [SIDE3-1:0]         n3_side;
    lavm_pkg::unit_t          n3_back;
    lavm_pkg::unit_t          n3_right;
    lavm_pkg::pos_t           n3_pos;
    lavm_pkg::unit_t          rows_in [3];
    lavm_pkg::unit_t          rows_out [3];
    logic signed [POS_W-1:0]  trans [3];
    logic                     x_valid;
    logic [lavm_pkg::OUT_W-1:0] result;

    // Configuration registers.
    assign pready  = 1'b1;
    assign cfg_idx = paddr[lavm_pkg::ADDR_W-1:2];
    assign cfg_wr  = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_x_reg <= '0;
            up_y_reg <= UNIT_W'(lavm_pkg::ONE_Q16);
            up_z_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                lavm_pkg::REG_UP_X: up_x_reg <= pwdata[UNIT_W-1:0];
                lavm_pkg::REG_UP_Y: up_y_reg <= pwdata[UNIT_W-1:0];
                lavm_pkg::REG_UP_Z: up_z_reg <= pwdata[UNIT_W-1:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            lavm_pkg::REG_UP_X: prdata = lavm_pkg::APB_W'(up_x_reg);
            lavm_pkg::REG_UP_Y: prdata = lavm_pkg::APB_W'(up_y_reg);
            lavm_pkg::REG_UP_Z: prdata = lavm_pkg::APB_W'(up_z_reg);
            default:            prdata = '0;
        endcase
    end

    // Input unpacking.
    assign in_pos      = s_tdata[3*POS_W-1:0];
    assign neg_front.x = -VEC_W'($signed(s_tdata[4*POS_W-1:3*POS_W]));
    assign neg_front.y = -VEC_W'($signed(s_tdata[5*POS_W-1:4*POS_W]));
    assign neg_front.z = -VEC_W'($signed(s_tdata[6*POS_W-1:5*POS_W]));
    assign up_vec.x    = up_x_reg;
    assign up_vec.y    = up_y_reg;
    assign up_vec.z    = up_z_reg;
    assign s_tready    = en;

    lavm_norm #(.SIDE_W(SIDE1)) u_norm_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (s_tvalid),
        .in_vec   (neg_front),
        .in_side  (in_pos),
        .out_valid(n1_valid),
        .out_vec  (n1_back),
        .out_side (n1_side)
    );

    lavm_cross #(.SIDE_W(SIDE2)) u_cross_right (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (n1_valid),
        .a        (up_vec),
        .b        (n1_back),
        .in_side  ({n1_back, n1_side}),
        .out_valid(c1_valid),
        .out_vec  (c1_vec),
        .out_side (c1_side)
    );

    lavm_norm #(.SIDE_W(SIDE2)) u_norm_right (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (c1_valid),
        .in_vec   (c1_vec),
        .in_side  (c1_side),
        .out_valid(n2_valid),
        .out_vec  (n2_right),
        .out_side (n2_side)
    );

    assign n2_back = n2_side[SIDE2-1:SIDE1];

    lavm_cross #(.SIDE_W(SIDE3)) u_cross_up (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (n2_valid),
        .a        (n2_back),
        .b        (n2_right),
        .in_side  ({n2_right, n2_side}),
        .out_valid(c2_valid),
        .out_vec  (c2_vec),
        .out_side (c2_side)
    );

    lavm_norm #(.SIDE_W(SIDE3)) u_norm_up (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (c2_valid),
        .in_vec   (c2_vec),
        .in_side  (c2_side),
        .out_valid(n3_valid),
        .out_vec  (n3_cup),
        .out_side (n3_side)
    );

    assign n3_right   = n3_side[SIDE3-1:SIDE2];
    assign n3_back    = n3_side[SIDE2-1:SIDE1];
    assign n3_pos     = n3_side[SIDE1-1:0];
    assign rows_in[0] = n3_right;
    assign rows_in[1] = n3_cup;
    assign rows_in[2] = n3_back;

    lavm_xlate u_xlate (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (n3_valid),
        .rows_in  (rows_in),
        .pos      (n3_pos),
        .out_valid(x_valid),
        .rows_out (rows_out),
        .trans    (trans)
    );

    assign result = {{(lavm_pkg::OUT_W - 9*UNIT_W - 3*POS_W){1'b0}},
                     trans[2], trans[1], trans[0],
                     rows_out[2], rows_out[1], rows_out[0]};

    lavm_obuf #(.W(lavm_pkg::OUT_W)) u_obuf (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (x_valid),
        .in_data  (result),
        .in_ready (en),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_data (m_tdata)
    );

endmodule

// File: hdl/lavm_checker.sv
// Port-level checker for the look-at view matrix core, bound to the top level.
// Depends on lavm_pkg and look_at_view_matrix_core.
module lavm_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         s_tready,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [lavm_pkg::OUT_W-1:0]   m_tdata,
    input logic                         psel,
    input logic                         penable,
    input logic                         pwrite,
    input logic [lavm_pkg::ADDR_W-1:0]  paddr,
    input logic [lavm_pkg::APB_W-1:0]   pwdata,
    input logic [lavm_pkg::APB_W-1:0]   prdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result transaction changed while stalled");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input blocked with an empty output buffer");

    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata[17:0]) <= 18'sd65536 &&
                      $signed(m_tdata[17:0]) >= -18'sd65536))
        else $error("right_x outside the unit range");

    a_reg_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && paddr[3:2] == lavm_pkg::REG_UP_X) |=>
        (paddr[3:2] != lavm_pkg::REG_UP_X || prdata[17:0] == $past(pwdata[17:0])))
        else $error("up_x readback differs from the written value");

endmodule

bind look_at_view_matrix_core lavm_checker u_lavm_checker (.*);
